### rtl/core/amf0_script_data_tokenizer_assert.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef AMF0_SCRIPT_DATA_TOKENIZER_ASSERT_SVH
`define AMF0_SCRIPT_DATA_TOKENIZER_ASSERT_SVH

`ifndef SYNTH

// Checked on every rising clk edge, quiet while arst_n is low.
`define AMF0_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("amf0 tokenizer assertion failed");

// Checked on every rising clk edge, reset included.
`define AMF0_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("amf0 tokenizer assertion failed");

`else

`define AMF0_ASSERT(lbl, prop)
`define AMF0_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

### rtl/core/amf0_pkg.sv
// Types and constants of the AMF0 script-data tokenizer.
package amf0_pkg;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       tag_start;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  event_kind;
		logic [63:0] payload;
		logic        string_last;
		logic [31:0] entry_index;
		logic [1:0]  error_code;
	} out_item_t;

	typedef struct packed {
		logic      valid;
		out_item_t item;
	} result_t;

	typedef enum logic [3:0] {
		PH_TOP       = 4'd0,
		PH_END_A     = 4'd1,
		PH_END_B     = 4'd2,
		PH_STR_HI    = 4'd3,
		PH_STR_LO    = 4'd4,
		PH_STR_BYTES = 4'd5,
		PH_COUNT     = 4'd6,
		PH_VAL_TYPE  = 4'd7,
		PH_NUMBER    = 4'd8,
		PH_BOOL      = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		ST_RUN    = 2'd0,
		ST_ENDED  = 2'd1,
		ST_FAILED = 2'd2
	} status_t;

	localparam logic [3:0] EV_NUMBER = 4'd3;
	localparam logic [3:0] EV_BOOL   = 4'd4;
	localparam logic [3:0] EV_COUNT  = 4'd5;
	localparam logic [3:0] EV_END    = 4'd6;
	localparam logic [3:0] EV_ERROR  = 4'd7;
	localparam logic [3:0] EV_EMPTY  = 4'd8;

	// string context doubles as the byte event kind
	localparam logic [1:0] CTX_TOP = 2'd0;
	localparam logic [1:0] CTX_KEY = 2'd1;
	localparam logic [1:0] CTX_VAL = 2'd2;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_TOP_TYPE = 2'd1;
	localparam logic [1:0] ERR_VAL_TYPE = 2'd2;

	localparam logic [7:0] TYPE_NUMBER = 8'h00;
	localparam logic [7:0] TYPE_BOOL   = 8'h01;
	localparam logic [7:0] TYPE_STRING = 8'h02;
	localparam logic [7:0] TYPE_ECMA   = 8'h08;
	localparam logic [7:0] END_MARK    = 8'h09;
	localparam logic [7:0] END_ZERO    = 8'h00;

	localparam logic [15:0] COUNT_BYTES  = 16'd4;
	localparam logic [15:0] NUMBER_BYTES = 16'd8;

endpackage

### rtl/core/amf0_parse.sv
// Parser state and per-byte token decode.
`include "amf0_script_data_tokenizer_assert.svh"

module amf0_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  amf0_pkg::in_item_t item,
	output amf0_pkg::result_t  res
);

	amf0_pkg::phase_t  phase_q, phase_n, cur_phase;
	amf0_pkg::status_t status_q, status_n, cur_status;
	logic [15:0] bytes_left_q, bytes_left_n, cur_bytes;
	logic [31:0] entries_left_q, entries_left_n, cur_entries;
	logic [31:0] entry_counter_q, entry_counter_n, cur_counter;
	logic [63:0] value_shift_q, value_shift_n, cur_shift;
	logic [1:0]  ctx_q, ctx_n, cur_ctx;

	logic [7:0]  b;
	logic [15:0] bytes_dec;
	logic [15:0] str_len;
	logic [63:0] shift_in;
	logic [31:0] entries_dec;
	logic [31:0] counter_inc;
	logic [31:0] ctx_index;

	// tag_start clears the state before the byte is parsed
	always_comb begin
		b = item.byte_value;
		if (item.tag_start) begin
			cur_phase   = amf0_pkg::PH_TOP;
			cur_status  = amf0_pkg::ST_RUN;
			cur_bytes   = '0;
			cur_entries = '0;
			cur_counter = '0;
			cur_shift   = '0;
			cur_ctx     = amf0_pkg::CTX_TOP;
		end else begin
			cur_phase   = phase_q;
			cur_status  = status_q;
			cur_bytes   = bytes_left_q;
			cur_entries = entries_left_q;
			cur_counter = entry_counter_q;
			cur_shift   = value_shift_q;
			cur_ctx     = ctx_q;
		end
		bytes_dec   = cur_bytes - 16'd1;
		str_len     = {cur_shift[7:0], b};
		shift_in    = {cur_shift[55:0], b};
		entries_dec = cur_entries - 32'd1;
		counter_inc = cur_counter + 32'd1;
		ctx_index   = (cur_ctx == amf0_pkg::CTX_TOP) ? '0 : cur_counter;
	end

	// next state
	always_comb begin
		phase_n         = cur_phase;
		status_n        = cur_status;
		bytes_left_n    = cur_bytes;
		entries_left_n  = cur_entries;
		entry_counter_n = cur_counter;
		value_shift_n   = cur_shift;
		ctx_n           = cur_ctx;
		if (cur_status == amf0_pkg::ST_RUN) begin
			unique case (cur_phase)
				amf0_pkg::PH_TOP: begin
					if (b == amf0_pkg::TYPE_STRING) begin
						ctx_n   = amf0_pkg::CTX_TOP;
						phase_n = amf0_pkg::PH_STR_HI;
					end else if (b == amf0_pkg::TYPE_ECMA) begin
						value_shift_n = '0;
						bytes_left_n  = amf0_pkg::COUNT_BYTES;
						phase_n       = amf0_pkg::PH_COUNT;
					end else if (b == amf0_pkg::END_ZERO) begin
						phase_n = amf0_pkg::PH_END_A;
					end else begin
						status_n = amf0_pkg::ST_FAILED;
					end
				end
				amf0_pkg::PH_END_A: begin
					if (b == amf0_pkg::END_ZERO) begin
						phase_n = amf0_pkg::PH_END_B;
					end else begin
						status_n = amf0_pkg::ST_FAILED;
					end
				end
				amf0_pkg::PH_END_B: begin
					status_n = (b == amf0_pkg::END_MARK) ? amf0_pkg::ST_ENDED
						: amf0_pkg::ST_FAILED;
				end
				amf0_pkg::PH_STR_HI: begin
					value_shift_n = {56'd0, b};
					phase_n       = amf0_pkg::PH_STR_LO;
				end
				amf0_pkg::PH_STR_LO, amf0_pkg::PH_STR_BYTES: begin
					bytes_left_n = (cur_phase == amf0_pkg::PH_STR_LO) ? str_len : bytes_dec;
					if (bytes_left_n != '0) begin
						phase_n = amf0_pkg::PH_STR_BYTES;
					end else if (cur_ctx == amf0_pkg::CTX_TOP) begin
						phase_n = amf0_pkg::PH_TOP;
					end else if (cur_ctx == amf0_pkg::CTX_KEY) begin
						phase_n = amf0_pkg::PH_VAL_TYPE;
					end else begin
						// value string done: move to next entry
						entries_left_n  = entries_dec;
						entry_counter_n = counter_inc;
						if (entries_dec == '0) begin
							phase_n = amf0_pkg::PH_TOP;
						end else begin
							ctx_n   = amf0_pkg::CTX_KEY;
							phase_n = amf0_pkg::PH_STR_HI;
						end
					end
				end
				amf0_pkg::PH_COUNT: begin
					value_shift_n = shift_in;
					bytes_left_n  = bytes_dec;
					if (bytes_dec == '0) begin
						entries_left_n  = shift_in[31:0];
						entry_counter_n = '0;
						if (shift_in[31:0] == '0) begin
							phase_n = amf0_pkg::PH_TOP;
						end else begin
							ctx_n   = amf0_pkg::CTX_KEY;
							phase_n = amf0_pkg::PH_STR_HI;
						end
					end
				end
				amf0_pkg::PH_VAL_TYPE: begin
					if (b == amf0_pkg::TYPE_NUMBER) begin
						value_shift_n = '0;
						bytes_left_n  = amf0_pkg::NUMBER_BYTES;
						phase_n       = amf0_pkg::PH_NUMBER;
					end else if (b == amf0_pkg::TYPE_BOOL) begin
						phase_n = amf0_pkg::PH_BOOL;
					end else if (b == amf0_pkg::TYPE_STRING) begin
						ctx_n   = amf0_pkg::CTX_VAL;
						phase_n = amf0_pkg::PH_STR_HI;
					end else begin
						status_n = amf0_pkg::ST_FAILED;
					end
				end
				amf0_pkg::PH_NUMBER, amf0_pkg::PH_BOOL: begin
					if (cur_phase == amf0_pkg::PH_NUMBER) begin
						value_shift_n = shift_in;
						bytes_left_n  = bytes_dec;
					end
					if (cur_phase == amf0_pkg::PH_BOOL || bytes_dec == '0) begin
						entries_left_n  = entries_dec;
						entry_counter_n = counter_inc;
						if (entries_dec == '0) begin
							phase_n = amf0_pkg::PH_TOP;
						end else begin
							ctx_n   = amf0_pkg::CTX_KEY;
							phase_n = amf0_pkg::PH_STR_HI;
						end
					end
				end
				default: begin
					phase_n = amf0_pkg::PH_TOP;
				end
			endcase
		end
	end

	// result
	always_comb begin
		res = '0;
		if (cur_status == amf0_pkg::ST_RUN) begin
			unique case (cur_phase)
				amf0_pkg::PH_TOP: begin
					if (b != amf0_pkg::TYPE_STRING && b != amf0_pkg::TYPE_ECMA &&
					    b != amf0_pkg::END_ZERO) begin
						res.valid           = 1'b1;
						res.item.event_kind = amf0_pkg::EV_ERROR;
						res.item.payload    = {56'd0, b};
						res.item.error_code = amf0_pkg::ERR_TOP_TYPE;
					end
				end
				amf0_pkg::PH_END_A: begin
					if (b != amf0_pkg::END_ZERO) begin
						res.valid           = 1'b1;
						res.item.event_kind = amf0_pkg::EV_ERROR;
						res.item.error_code = amf0_pkg::ERR_TOP_TYPE;
					end
				end
				amf0_pkg::PH_END_B: begin
					res.valid = 1'b1;
					if (b == amf0_pkg::END_MARK) begin
						res.item.event_kind = amf0_pkg::EV_END;
					end else begin
						res.item.event_kind = amf0_pkg::EV_ERROR;
						res.item.error_code = amf0_pkg::ERR_TOP_TYPE;
					end
				end
				amf0_pkg::PH_STR_LO: begin
					if (str_len == '0) begin
						res.valid            = 1'b1;
						res.item.event_kind  = amf0_pkg::EV_EMPTY;
						res.item.payload     = {62'd0, cur_ctx};
						res.item.entry_index = ctx_index;
					end
				end
				amf0_pkg::PH_STR_BYTES: begin
					res.valid            = 1'b1;
					res.item.event_kind  = {2'b00, cur_ctx};
					res.item.payload     = {56'd0, b};
					res.item.string_last = (bytes_dec == '0);
					res.item.entry_index = ctx_index;
				end
				amf0_pkg::PH_COUNT: begin
					if (bytes_dec == '0) begin
						res.valid           = 1'b1;
						res.item.event_kind = amf0_pkg::EV_COUNT;
						res.item.payload    = {32'd0, shift_in[31:0]};
					end
				end
				amf0_pkg::PH_VAL_TYPE: begin
					if (b != amf0_pkg::TYPE_NUMBER && b != amf0_pkg::TYPE_BOOL &&
					    b != amf0_pkg::TYPE_STRING) begin
						res.valid            = 1'b1;
						res.item.event_kind  = amf0_pkg::EV_ERROR;
						res.item.payload     = {56'd0, b};
						res.item.entry_index = cur_counter;
						res.item.error_code  = amf0_pkg::ERR_VAL_TYPE;
					end
				end
				amf0_pkg::PH_NUMBER: begin
					if (bytes_dec == '0) begin
						res.valid            = 1'b1;
						res.item.event_kind  = amf0_pkg::EV_NUMBER;
						res.item.payload     = shift_in;
						res.item.entry_index = cur_counter;
					end
				end
				amf0_pkg::PH_BOOL: begin
					res.valid            = 1'b1;
					res.item.event_kind  = amf0_pkg::EV_BOOL;
					res.item.payload     = {56'd0, b};
					res.item.entry_index = cur_counter;
				end
				default: begin
					res.valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= amf0_pkg::PH_TOP;
			status_q        <= amf0_pkg::ST_RUN;
			bytes_left_q    <= '0;
			entries_left_q  <= '0;
			entry_counter_q <= '0;
			value_shift_q   <= '0;
			ctx_q           <= amf0_pkg::CTX_TOP;
		end else if (fire) begin
			phase_q         <= phase_n;
			status_q        <= status_n;
			bytes_left_q    <= bytes_left_n;
			entries_left_q  <= entries_left_n;
			entry_counter_q <= entry_counter_n;
			value_shift_q   <= value_shift_n;
			ctx_q           <= ctx_n;
		end
	end

	`AMF0_ASSERT(a_str_bytes_nonzero, phase_q == amf0_pkg::PH_STR_BYTES |-> bytes_left_q != '0)
	`AMF0_ASSERT(a_sticky_silent, fire && status_q != amf0_pkg::ST_RUN && !item.tag_start |-> !res.valid)
	`AMF0_ASSERT(a_term_sets_status, fire && res.valid && (res.item.event_kind == amf0_pkg::EV_END || res.item.event_kind == amf0_pkg::EV_ERROR) |=> status_q != amf0_pkg::ST_RUN)

endmodule

### rtl/core/amf0_script_data_tokenizer.sv
// Top level of the AMF0 script-data tokenizer: input and result registers.
//
//  channel | signals                             | direction
//  --------+-------------------------------------+----------
//  byte    | byte_valid, byte_stall, byte_data   | in
//  event   | event_valid, event_stall, event_data| out
//
// One byte per cycle sustained while byte_stall is low; each byte is held in the
// input register, decoded, and its result registered in the result register.
// A byte that yields no token updates state and leaves no result.
// arst_n clears all parser state; tag_start in a byte clears it as well.
// byte_stall rises only when the input register holds a byte and the result
// register is full and stalled.
`include "amf0_script_data_tokenizer_assert.svh"

module amf0_script_data_tokenizer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  amf0_pkg::in_item_t  byte_data,
	output logic                event_valid,
	input  logic                event_stall,
	output amf0_pkg::out_item_t event_data
);

	logic                in_valid_s1;
	amf0_pkg::in_item_t  in_item_s1;
	logic                out_valid_q;
	amf0_pkg::out_item_t out_q;
	logic                fire;
	amf0_pkg::result_t   res;

	assign fire       = in_valid_s1 && (!out_valid_q || !event_stall);
	assign byte_stall = in_valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			in_valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall) begin
			in_item_s1 <= byte_data;
		end
	end

	amf0_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (in_item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!event_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.valid) begin
			out_q <= res.item;
		end
	end

	assign event_valid = out_valid_q;
	assign event_data  = out_q;

	`AMF0_ASSERT(a_result_lands, fire && res.valid |=> out_valid_q)
	`AMF0_ASSERT(a_stall_needs_item, byte_stall |-> in_valid_s1)
	`AMF0_ASSERT_ALWAYS(a_free_slot_no_stall, !out_valid_q |-> !byte_stall)

endmodule

### tb/sv/tb.sv
// Testbench for the AMF0 script-data tokenizer: directed and random byte streams against a parser model.
module tb;

	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 20;

	logic                clk;
	logic                arst_n;
	logic                byte_valid;
	logic                byte_stall;
	amf0_pkg::in_item_t  byte_data;
	logic                event_valid;
	logic                event_stall;
	amf0_pkg::out_item_t event_data;

	amf0_script_data_tokenizer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.event_valid(event_valid),
		.event_stall(event_stall),
		.event_data (event_data)
	);

	// parser model state
	amf0_pkg::phase_t  phase;
	amf0_pkg::status_t status;
	logic [15:0] remaining;
	logic [31:0] entries;
	logic [31:0] entry_no;
	logic [63:0] shifter;
	logic [1:0]  ctx;

	amf0_pkg::in_item_t  body_q[$];
	amf0_pkg::out_item_t token_q[$];
	bit        body_open;

	int bytes_in, tokens_out, total_bytes, bodies;
	int ends_seen, errors_seen, fails, reported, quiet;
	bit byte_taken, event_taken, byte_calm, event_calm;
	int byte_gap, event_hold;
	amf0_pkg::out_item_t tok, want;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------- parser model ----------------

	function automatic void clear_parser();
		phase = amf0_pkg::PH_TOP;
		status = amf0_pkg::ST_RUN;
		remaining = '0;
		entries = '0;
		entry_no = '0;
		shifter = '0;
		ctx = amf0_pkg::CTX_TOP;
	endfunction

	function automatic amf0_pkg::out_item_t make_tok(input logic [3:0] kind,
			input logic [63:0] pl, input logic last, input logic [31:0] idx,
			input logic [1:0] err);
		amf0_pkg::out_item_t t;
		t.event_kind = kind;
		t.payload = pl;
		t.string_last = last;
		t.entry_index = idx;
		t.error_code = err;
		return t;
	endfunction

	function automatic void open_string(input logic [1:0] c);
		ctx = c;
		phase = amf0_pkg::PH_STR_HI;
	endfunction

	function automatic void advance_entry();
		entries--;
		entry_no++;
		if (entries == 0) begin
			phase = amf0_pkg::PH_TOP;
		end else begin
			open_string(amf0_pkg::CTX_KEY);
		end
	endfunction

	function automatic void close_string();
		if (ctx == amf0_pkg::CTX_TOP) begin
			phase = amf0_pkg::PH_TOP;
		end else if (ctx == amf0_pkg::CTX_KEY) begin
			phase = amf0_pkg::PH_VAL_TYPE;
		end else begin
			advance_entry();
		end
	endfunction

	function automatic logic [31:0] string_index();
		return (ctx == amf0_pkg::CTX_TOP) ? 32'd0 : entry_no;
	endfunction

	// returns 1 when the byte yields a token
	function automatic bit tokenize_byte(input amf0_pkg::in_item_t it,
			output amf0_pkg::out_item_t t);
		logic [7:0] b;
		logic [31:0] idx;
		b = it.byte_value;
		t = '0;
		if (it.tag_start)
			clear_parser();
		if (status != amf0_pkg::ST_RUN)
			return 1'b0;
		case (phase)
		amf0_pkg::PH_TOP: begin
			if (b == amf0_pkg::TYPE_STRING) begin
				open_string(amf0_pkg::CTX_TOP);
			end else if (b == amf0_pkg::TYPE_ECMA) begin
				shifter = '0;
				remaining = amf0_pkg::COUNT_BYTES;
				phase = amf0_pkg::PH_COUNT;
			end else if (b == amf0_pkg::END_ZERO) begin
				phase = amf0_pkg::PH_END_A;
			end else begin
				status = amf0_pkg::ST_FAILED;
				t = make_tok(amf0_pkg::EV_ERROR, {56'd0, b}, 1'b0, 32'd0,
					amf0_pkg::ERR_TOP_TYPE);
				return 1'b1;
			end
			return 1'b0;
		end
		amf0_pkg::PH_END_A: begin
			if (b == amf0_pkg::END_ZERO) begin
				phase = amf0_pkg::PH_END_B;
				return 1'b0;
			end
			status = amf0_pkg::ST_FAILED;
			t = make_tok(amf0_pkg::EV_ERROR, 64'd0, 1'b0, 32'd0, amf0_pkg::ERR_TOP_TYPE);
			return 1'b1;
		end
		amf0_pkg::PH_END_B: begin
			if (b == amf0_pkg::END_MARK) begin
				status = amf0_pkg::ST_ENDED;
				t = make_tok(amf0_pkg::EV_END, 64'd0, 1'b0, 32'd0, amf0_pkg::ERR_NONE);
			end else begin
				status = amf0_pkg::ST_FAILED;
				t = make_tok(amf0_pkg::EV_ERROR, 64'd0, 1'b0, 32'd0,
					amf0_pkg::ERR_TOP_TYPE);
			end
			return 1'b1;
		end
		amf0_pkg::PH_STR_HI: begin
			shifter = {56'd0, b};
			phase = amf0_pkg::PH_STR_LO;
			return 1'b0;
		end
		amf0_pkg::PH_STR_LO: begin
			remaining = {shifter[7:0], b};
			if (remaining == 0) begin
				t = make_tok(amf0_pkg::EV_EMPTY, {62'd0, ctx}, 1'b0, string_index(),
					amf0_pkg::ERR_NONE);
				close_string();
				return 1'b1;
			end
			phase = amf0_pkg::PH_STR_BYTES;
			return 1'b0;
		end
		amf0_pkg::PH_STR_BYTES: begin
			remaining--;
			t = make_tok({2'b00, ctx}, {56'd0, b}, remaining == 0, string_index(),
				amf0_pkg::ERR_NONE);
			if (remaining == 0)
				close_string();
			return 1'b1;
		end
		amf0_pkg::PH_COUNT: begin
			shifter = {shifter[55:0], b};
			remaining--;
			if (remaining != 0)
				return 1'b0;
			entries = shifter[31:0];
			entry_no = '0;
			t = make_tok(amf0_pkg::EV_COUNT, {32'd0, entries}, 1'b0, 32'd0,
				amf0_pkg::ERR_NONE);
			if (entries == 0) begin
				phase = amf0_pkg::PH_TOP;
			end else begin
				open_string(amf0_pkg::CTX_KEY);
			end
			return 1'b1;
		end
		amf0_pkg::PH_VAL_TYPE: begin
			if (b == amf0_pkg::TYPE_NUMBER) begin
				shifter = '0;
				remaining = amf0_pkg::NUMBER_BYTES;
				phase = amf0_pkg::PH_NUMBER;
			end else if (b == amf0_pkg::TYPE_BOOL) begin
				phase = amf0_pkg::PH_BOOL;
			end else if (b == amf0_pkg::TYPE_STRING) begin
				open_string(amf0_pkg::CTX_VAL);
			end else begin
				status = amf0_pkg::ST_FAILED;
				t = make_tok(amf0_pkg::EV_ERROR, {56'd0, b}, 1'b0, entry_no,
					amf0_pkg::ERR_VAL_TYPE);
				return 1'b1;
			end
			return 1'b0;
		end
		amf0_pkg::PH_NUMBER: begin
			shifter = {shifter[55:0], b};
			remaining--;
			if (remaining != 0)
				return 1'b0;
			idx = entry_no;
			t = make_tok(amf0_pkg::EV_NUMBER, shifter, 1'b0, idx, amf0_pkg::ERR_NONE);
			advance_entry();
			return 1'b1;
		end
		amf0_pkg::PH_BOOL: begin
			idx = entry_no;
			t = make_tok(amf0_pkg::EV_BOOL, {56'd0, b}, 1'b0, idx, amf0_pkg::ERR_NONE);
			advance_entry();
			return 1'b1;
		end
		default: begin
			phase = amf0_pkg::PH_TOP;
			return 1'b0;
		end
		endcase
	endfunction

	// ---------------- stream builders ----------------

	function automatic void put(input logic [7:0] b, input bit restart = 1'b0);
		amf0_pkg::in_item_t it;
		it.byte_value = b;
		it.tag_start = body_open | restart;
		body_open = 1'b0;
		body_q.push_back(it);
	endfunction

	function automatic void put_string(input logic [15:0] len);
		put(len[15:8]);
		put(len[7:0]);
		repeat (len) put(8'($urandom));
	endfunction

	function automatic logic [15:0] pick_len();
		if ($urandom_range(0, 149) == 0)
			return 16'($urandom_range(256, 270));
		return 16'($urandom_range(0, 6));
	endfunction

	// returns 0 when the body is finished early (bad value type or cut short)
	function automatic bit random_array();
		logic [31:0] n;
		logic [7:0] bad;
		int shown, sel;
		if ($urandom_range(0, 9) == 0)
			n = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
		else
			n = $urandom_range(0, 4);
		put(amf0_pkg::TYPE_ECMA);
		put(n[31:24]);
		put(n[23:16]);
		put(n[15:8]);
		put(n[7:0]);
		shown = (n > 4) ? int'($urandom_range(0, 2)) : int'(n);
		for (int i = 0; i < shown; i++) begin
			put_string(pick_len());
			sel = $urandom_range(0, 99);
			if (sel < 35) begin
				put(amf0_pkg::TYPE_NUMBER);
				repeat (8) put(8'($urandom));
			end else if (sel < 65) begin
				put(amf0_pkg::TYPE_BOOL);
				put($urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 1)));
			end else if (sel < 94) begin
				put(amf0_pkg::TYPE_STRING);
				put_string(pick_len());
			end else begin
				do bad = 8'($urandom); while (bad <= amf0_pkg::TYPE_STRING);
				put(bad);
				return 1'b0;
			end
		end
		return shown == n;
	endfunction

	function automatic void random_body();
		int elems;
		body_open = 1'b1;
		bodies++;
		if ($urandom_range(0, 99) < 15) begin
			// noise, with the odd restart in the middle
			repeat ($urandom_range(1, 8))
				put(8'($urandom), $urandom_range(0, 9) == 0);
			return;
		end
		elems = $urandom_range(1, 3);
		repeat (elems) begin
			if ($urandom_range(0, 1)) begin
				put(amf0_pkg::TYPE_STRING);
				put_string(pick_len());
			end else if (!random_array()) begin
				return;
			end
			if ($urandom_range(0, 19) == 0)
				return;
		end
		if ($urandom_range(0, 9) != 0) begin
			put(amf0_pkg::END_ZERO);
			put(amf0_pkg::END_ZERO);
			put(amf0_pkg::END_MARK);
			// trailing bytes after end are dropped
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) put(8'($urandom));
		end else begin
			put(amf0_pkg::END_ZERO);
			put(8'($urandom));
			put(8'($urandom));
		end
	endfunction

	function automatic int draw_wait(input bit calm);
		return calm ? 0 : int'($urandom_range(0, 19));
	endfunction

	// ---------------- driver ----------------

	always @(negedge clk) begin
		if (arst_n) begin
			if (!byte_valid || byte_taken) begin
				if (byte_gap > 0) begin
					byte_valid <= 1'b0;
					byte_gap--;
				end else if (body_q.size() > 0) begin
					byte_data <= body_q.pop_front();
					byte_valid <= 1'b1;
					if ($urandom_range(0, 39) == 0)
						byte_calm = !byte_calm;
					byte_gap = draw_wait(byte_calm);
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (event_taken) begin
				if ($urandom_range(0, 39) == 0)
					event_calm = !event_calm;
				event_hold = draw_wait(event_calm);
			end
			event_stall <= (event_hold != 0);
			if (event_hold != 0 && event_valid)
				event_hold--;
		end
	end

	// ---------------- monitor ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_taken <= 1'b0;
			event_taken <= 1'b0;
		end else begin
			byte_taken <= byte_valid && !byte_stall;
			event_taken <= event_valid && !event_stall;
			if (byte_valid && !byte_stall) begin
				bytes_in++;
				if (tokenize_byte(byte_data, tok)) begin
					token_q.push_back(tok);
					if (tok.event_kind == amf0_pkg::EV_END)
						ends_seen++;
					if (tok.event_kind == amf0_pkg::EV_ERROR)
						errors_seen++;
				end
			end
			if (event_valid && !event_stall) begin
				tokens_out++;
				if (token_q.size() == 0) begin
					fails++;
					if (reported < 10) begin
						reported++;
						$display("tb: unexpected token kind %0d payload %h",
							event_data.event_kind, event_data.payload);
					end
				end else begin
					want = token_q.pop_front();
					if (event_data.event_kind !== want.event_kind ||
							event_data.payload !== want.payload ||
							event_data.string_last !== want.string_last ||
							event_data.entry_index !== want.entry_index ||
							event_data.error_code !== want.error_code) begin
						fails++;
						if (reported < 10) begin
							reported++;
							$display("tb: token %0d want kind %0d pl %h last %0d idx %0d err %0d",
								tokens_out, want.event_kind, want.payload,
								want.string_last, want.entry_index, want.error_code);
							$display("tb: token %0d got  kind %0d pl %h last %0d idx %0d err %0d",
								tokens_out, event_data.event_kind, event_data.payload,
								event_data.string_last, event_data.entry_index,
								event_data.error_code);
						end
					end
				end
			end
		end
	end

	// watchdog: a long stretch with no request moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && !byte_stall) || (event_valid && !event_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet == QUIET_LIMIT) begin
				$display("tb: no progress, %0d tokens still pending", token_q.size());
				$display("tb: done, errors");
				$finish;
			end
		end
	end

	// ---------------- stimulus and end of run ----------------

	initial begin
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_data = '0;
		event_stall = 1'b0;
		clear_parser();

		// end marker, then a dropped byte
		body_open = 1'b1;
		bodies++;
		put(amf0_pkg::END_ZERO);
		put(amf0_pkg::END_ZERO);
		put(amf0_pkg::END_MARK);
		put(8'h55);
		// empty and one-byte top strings, empty array, end
		body_open = 1'b1;
		bodies++;
		put(amf0_pkg::TYPE_STRING);
		put(8'h00);
		put(8'h00);
		put(amf0_pkg::TYPE_STRING);
		put(8'h00);
		put(8'h01);
		put(8'hFF);
		put(amf0_pkg::TYPE_ECMA);
		repeat (4) put(8'h00);
		put(amf0_pkg::END_ZERO);
		put(amf0_pkg::END_ZERO);
		put(amf0_pkg::END_MARK);
		// bad top-level type
		body_open = 1'b1;
		bodies++;
		put(8'hFF);
		// end marker broken after its first and second byte
		body_open = 1'b1;
		bodies++;
		put(amf0_pkg::END_ZERO);
		put(8'h05);
		body_open = 1'b1;
		bodies++;
		put(amf0_pkg::END_ZERO);
		put(amf0_pkg::END_ZERO);
		put(8'h07);

		while (body_q.size() < 900)
			random_body();
		total_bytes = body_q.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (bytes_in == total_bytes);
		while (token_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb: %0d bytes in %0d bodies, %0d tokens checked", bytes_in, bodies, tokens_out);
		$display("tb: %0d end markers, %0d parse errors, %0d mismatches",
			ends_seen, errors_seen, fails);
		if (fails == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
